@@ design/mcpid_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mcpid_pkg: shared types and constants
// Field widths, register indexes, mode codes and the structs passed between
// the top level and the PID engine of the cascaded motor controller.
// ----------------------------------------------------------------------------
package mcpid_pkg;

  localparam int ANGLE_W  = 13;
  localparam int SPEED_W  = 16;
  localparam int TARGET_W = 32;
  localparam int MODE_W   = 2;
  localparam int DRIVE_W  = 16;
  localparam int TPOS_W   = 32;
  localparam int ROUND_W  = 18;
  localparam int GAIN_W   = 24;
  localparam int MAXO_W   = 15;
  localparam int CFG_W    = 24;
  localparam int IDX_W    = 3;

  // arithmetic of the PID engine
  localparam int ERR_W    = 33;
  localparam int DIFF_W   = 34;
  localparam int HALF_W   = 17;              // operand split point
  localparam int MUL_A_W  = GAIN_W + 1;
  localparam int MUL_B_W  = HALF_W + 1;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 64;
  localparam int INTEG_W  = 48;

  localparam logic signed [ACC_W-1:0] INTEG_MAX = {{(ACC_W-INTEG_W+1){1'b0}},
                                                   {(INTEG_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] INTEG_MIN = {{(ACC_W-INTEG_W+1){1'b1}},
                                                   {(INTEG_W-1){1'b0}}};

  localparam logic signed [TARGET_W-1:0] DRIVE_HI = 32'sd32767;
  localparam logic signed [TARGET_W-1:0] DRIVE_LO = -32'sd32768;

  // register indexes
  localparam logic [IDX_W-1:0] REG_KP_VEL = 3'd0;
  localparam logic [IDX_W-1:0] REG_KI_VEL = 3'd1;
  localparam logic [IDX_W-1:0] REG_KD_VEL = 3'd2;
  localparam logic [IDX_W-1:0] REG_KP_POS = 3'd3;
  localparam logic [IDX_W-1:0] REG_KI_POS = 3'd4;
  localparam logic [IDX_W-1:0] REG_KD_POS = 3'd5;
  localparam logic [IDX_W-1:0] REG_MAXOUT = 3'd6;
  localparam logic [IDX_W-1:0] REG_OFFSET = 3'd7;

  localparam logic [MAXO_W-1:0] MAXOUT_RESET = 15'd16384;

  // control tick modes
  localparam logic [MODE_W-1:0] MODE_CURRENT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VELOCITY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POSITION = 2'd2;
  localparam logic [MODE_W-1:0] MODE_STOP     = 2'd3;

  // item kinds
  localparam logic CMD_FEEDBACK = 1'b0;
  localparam logic CMD_CONTROL  = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp_vel;
    logic [GAIN_W-1:0]  ki_vel;
    logic [GAIN_W-1:0]  kd_vel;
    logic [GAIN_W-1:0]  kp_pos;
    logic [GAIN_W-1:0]  ki_pos;
    logic [GAIN_W-1:0]  kd_pos;
    logic [MAXO_W-1:0]  max_output;
    logic [ANGLE_W-1:0] offset_angle;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic signed [TARGET_W-1:0] target;
    logic                       clear;
    logic signed [TPOS_W-1:0]   tpos;
    logic signed [SPEED_W-1:0]  speed;
  } req_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      clamped;
  } res_t;

endpackage
`default_nettype wire

@@ design/mcpid_item_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mcpid_item_if: input channel
// Valid/ready channel carrying feedback frames and control ticks.
// ----------------------------------------------------------------------------
interface mcpid_item_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic [mcpid_pkg::ANGLE_W-1:0]        rotor_angle;
  logic signed [mcpid_pkg::SPEED_W-1:0] rotor_speed;
  logic [mcpid_pkg::MODE_W-1:0]         mode;
  logic signed [mcpid_pkg::TARGET_W-1:0] target;
  logic                                 clear_integrals;

  modport source (output valid, cmd, rotor_angle, rotor_speed, mode, target,
                  clear_integrals, input ready);
  modport sink (input valid, cmd, rotor_angle, rotor_speed, mode, target,
                clear_integrals, output ready);
endinterface
`default_nettype wire

@@ design/mcpid_result_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mcpid_result_if: result channel
// Valid/ready channel carrying one result beat per control tick.
// ----------------------------------------------------------------------------
interface mcpid_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mcpid_pkg::DRIVE_W-1:0] drive_current;
  logic signed [mcpid_pkg::TPOS_W-1:0]  total_position;
  logic                                 output_clamped;

  modport source (output valid, drive_current, total_position, output_clamped,
                  input ready);
  modport sink (input valid, drive_current, total_position, output_clamped,
                output ready);
endinterface
`default_nettype wire

@@ design/mcpid_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mcpid_mul: shared multiplier
// Registered 25x18 signed multiplier; one partial product per enable.
// ----------------------------------------------------------------------------
module mcpid_mul (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic signed [mcpid_pkg::MUL_A_W-1:0]  a,
  input  wire logic signed [mcpid_pkg::MUL_B_W-1:0]  b,
  output      logic signed [mcpid_pkg::PROD_W-1:0]   p
);
  import mcpid_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule
`default_nettype wire

@@ design/mcpid_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mcpid_core: PID engine
// Sequencer running the position and velocity PID loops on one shared
// multiplier and accumulator; holds both loops' integrators and last errors.
// ----------------------------------------------------------------------------
module mcpid_core #(
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mcpid_pkg::cfg_t  cfg,
  input  wire logic             start,
  input  wire mcpid_pkg::req_t  req,
  output      logic             idle,
  output      logic             done,
  input  wire logic             take,
  output      mcpid_pkg::res_t  res
);
  import mcpid_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ERR   = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_ACC   = 7'b0001000,
    S_INTEG = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;

  logic                       loop_pos;   // 1: position loop active
  logic signed [ERR_W-1:0]    target_cur;
  logic signed [TPOS_W-1:0]   r_tpos;
  logic signed [SPEED_W-1:0]  r_speed;
  logic signed [ERR_W-1:0]    err;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [ACC_W-1:0]    acc;
  logic [2:0]                 term;

  logic signed [ERR_W-1:0]    vel_last_err, pos_last_err;
  logic signed [INTEG_W-1:0]  vel_integ, pos_integ;

  logic signed [PROD_W-1:0]   prod;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic [GAIN_W-1:0]          gain_sel;
  logic signed [DIFF_W-1:0]   val_sel;

  logic signed [ERR_W-1:0]    meas;
  logic signed [ERR_W-1:0]    last_sel;
  logic signed [ERR_W-1:0]    err_v;
  logic signed [ACC_W-1:0]    addend;
  logic signed [ACC_W-1:0]    integ_sum;
  logic signed [INTEG_W-1:0]  integ_new;
  logic signed [ACC_W-1:0]    shifted;
  logic signed [ACC_W-1:0]    lim;
  logic signed [DRIVE_W-1:0]  pid_out;
  logic                       pid_clamped;
  logic signed [DRIVE_W-1:0]  cur_drive;

  mcpid_mul u_mul (
    .clk (clk),
    .en  (state == S_MUL),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // operand select: ki*err, kp*err, kd*diff, low half then high half
  always_comb begin
    priority if (term < 3'd2) begin
      gain_sel = loop_pos ? cfg.ki_pos : cfg.ki_vel;
      val_sel  = DIFF_W'(err);
    end else if (term < 3'd4) begin
      gain_sel = loop_pos ? cfg.kp_pos : cfg.kp_vel;
      val_sel  = DIFF_W'(err);
    end else begin
      gain_sel = loop_pos ? cfg.kd_pos : cfg.kd_vel;
      val_sel  = diff;
    end
    mul_a = $signed({1'b0, gain_sel});
    if (term[0]) begin
      // high half carries the sign
      mul_b = MUL_B_W'($signed(val_sel[DIFF_W-1:HALF_W]));
    end else begin
      mul_b = $signed({1'b0, val_sel[HALF_W-1:0]});
    end
  end

  always_comb begin
    meas     = loop_pos ? ERR_W'(r_tpos) : ERR_W'(r_speed);
    last_sel = loop_pos ? pos_last_err : vel_last_err;
    err_v    = target_cur - meas;

    addend   = term[0] ? (ACC_W'(prod) <<< HALF_W) : ACC_W'(prod);

    integ_sum = ACC_W'(loop_pos ? pos_integ : vel_integ) + acc;
    priority if (integ_sum > INTEG_MAX) begin
      integ_new = INTEG_W'(INTEG_MAX);
    end else if (integ_sum < INTEG_MIN) begin
      integ_new = INTEG_W'(INTEG_MIN);
    end else begin
      integ_new = integ_sum[INTEG_W-1:0];
    end

    shifted = acc >>> GAIN_FRACTION_BITS;
    lim     = $signed(ACC_W'(cfg.max_output));
    priority if (shifted > lim) begin
      pid_out     = DRIVE_W'(lim);
      pid_clamped = 1'b1;
    end else if (shifted < -lim) begin
      pid_out     = DRIVE_W'(-lim);
      pid_clamped = 1'b1;
    end else begin
      pid_out     = shifted[DRIVE_W-1:0];
      pid_clamped = 1'b0;
    end

    priority if (req.target > DRIVE_HI) begin
      cur_drive = DRIVE_W'(DRIVE_HI);
    end else if (req.target < DRIVE_LO) begin
      cur_drive = DRIVE_W'(DRIVE_LO);
    end else begin
      cur_drive = req.target[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loop_pos     <= 1'b0;
      term         <= '0;
      vel_last_err <= '0;
      pos_last_err <= '0;
      vel_integ    <= '0;
      pos_integ    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r_tpos     <= req.tpos;
            r_speed    <= req.speed;
            target_cur <= ERR_W'(req.target);
            if (req.clear) begin
              vel_integ <= '0;
              pos_integ <= '0;
            end
            unique case (req.mode)
              MODE_CURRENT: begin
                res.drive   <= cur_drive;
                res.clamped <= 1'b0;
                state       <= S_DONE;
              end
              MODE_VELOCITY: begin
                loop_pos <= 1'b0;
                state    <= S_ERR;
              end
              MODE_POSITION: begin
                loop_pos <= 1'b1;
                state    <= S_ERR;
              end
              MODE_STOP: begin
                res.drive   <= '0;
                res.clamped <= 1'b0;
                state       <= S_DONE;
              end
            endcase
          end
        end
        S_ERR: begin
          err   <= err_v;
          diff  <= DIFF_W'(err_v) - DIFF_W'(last_sel);
          acc   <= '0;
          term  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          acc  <= acc + addend;
          term <= term + 3'd1;
          priority if (term == 3'd1) begin
            state <= S_INTEG;
          end else if (term == 3'd5) begin
            state <= S_OUT;
          end else begin
            state <= S_MUL;
          end
        end
        S_INTEG: begin
          if (loop_pos) begin
            pos_integ <= integ_new;
          end else begin
            vel_integ <= integ_new;
          end
          acc   <= ACC_W'(integ_new);
          state <= S_MUL;
        end
        S_OUT: begin
          if (loop_pos) begin
            // position output becomes the velocity loop target
            pos_last_err <= err;
            target_cur   <= ERR_W'(pid_out);
            loop_pos     <= 1'b0;
            state        <= S_ERR;
          end else begin
            vel_last_err <= err;
            res.drive    <= pid_out;
            res.clamped  <= pid_clamped;
            state        <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

endmodule
`default_nettype wire

@@ design/motor_cascade_pid_controller.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// motor_cascade_pid_controller: cascaded position/velocity PID for one motor
//
// Input channel "item" carries feedback frames (cmd 0) and control ticks
// (cmd 1). A feedback frame updates the angle, speed and round counter; it
// produces no result. A control tick produces one beat on the "result"
// channel. A PID loop sends its six partial products one after another
// through the single 25x18 multiplier and 64-bit accumulator. The item
// channel is not ready while a tick is worked on.
// A finished result sits in an output register; a stalled receiver holds it
// there, and feedback frames are still taken meanwhile. A further tick can
// complete its work but waits inside the engine until the register frees.
// Registers are written through wr_en/wr_index/wr_data; the user must write
// them only while idle, and the block itself does not enforce this.
// Synchronous reset clears all loop state and sets the register defaults
// (max_output 16384, gains and offset zero).
// ----------------------------------------------------------------------------
module motor_cascade_pid_controller #(
  parameter int COUNTS_PER_TURN    = 8192,
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  mcpid_item_if.sink                         item,
  mcpid_result_if.source                     result,
  input  wire logic                          wr_en,
  input  wire logic [mcpid_pkg::IDX_W-1:0]   wr_index,
  input  wire logic [mcpid_pkg::CFG_W-1:0]   wr_data
);
  import mcpid_pkg::*;

  localparam int HALF_TURN_W = 18;
  localparam logic signed [HALF_TURN_W-1:0] HALF_TURN = HALF_TURN_W'(COUNTS_PER_TURN / 2);
  localparam logic signed [TPOS_W-1:0]      TURN      = TPOS_W'(COUNTS_PER_TURN);

  cfg_t cfg;

  logic [ANGLE_W-1:0]         current_angle;
  logic signed [ROUND_W-1:0]  round_count;
  logic signed [SPEED_W-1:0]  latest_speed;

  logic signed [HALF_TURN_W-1:0] angle_diff;
  logic signed [TPOS_W-1:0]      tpos;

  logic   item_accept;
  logic   core_idle;
  logic   core_done;
  logic   core_take;
  req_t   req;
  res_t   res;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_vel       <= '0;
      cfg.ki_vel       <= '0;
      cfg.kd_vel       <= '0;
      cfg.kp_pos       <= '0;
      cfg.ki_pos       <= '0;
      cfg.kd_pos       <= '0;
      cfg.max_output   <= MAXOUT_RESET;
      cfg.offset_angle <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_KP_VEL: cfg.kp_vel       <= wr_data;
        REG_KI_VEL: cfg.ki_vel       <= wr_data;
        REG_KD_VEL: cfg.kd_vel       <= wr_data;
        REG_KP_POS: cfg.kp_pos       <= wr_data;
        REG_KI_POS: cfg.ki_pos       <= wr_data;
        REG_KD_POS: cfg.kd_pos       <= wr_data;
        REG_MAXOUT: cfg.max_output   <= wr_data[MAXO_W-1:0];
        REG_OFFSET: cfg.offset_angle <= wr_data[ANGLE_W-1:0];
      endcase
    end
  end

  assign item.ready  = core_idle;
  assign item_accept = item.valid && item.ready;

  // half-turn rule on the angle step
  assign angle_diff = $signed({{(HALF_TURN_W-ANGLE_W){1'b0}}, item.rotor_angle})
                    - $signed({{(HALF_TURN_W-ANGLE_W){1'b0}}, current_angle});

  always_ff @(posedge clk) begin
    if (rst) begin
      current_angle <= '0;
      round_count   <= '0;
      latest_speed  <= '0;
    end else if (item_accept && item.cmd == CMD_FEEDBACK) begin
      current_angle <= item.rotor_angle;
      latest_speed  <= item.rotor_speed;
      priority if (angle_diff > HALF_TURN) begin
        round_count <= round_count - ROUND_W'(1);
      end else if (angle_diff < -HALF_TURN) begin
        round_count <= round_count + ROUND_W'(1);
      end
    end
  end

  assign tpos = TPOS_W'(round_count) * TURN
              + $signed({{(TPOS_W-ANGLE_W){1'b0}}, current_angle})
              - $signed({{(TPOS_W-ANGLE_W){1'b0}}, cfg.offset_angle});

  assign req.mode   = item.mode;
  assign req.target = item.target;
  assign req.clear  = item.clear_integrals;
  assign req.tpos   = tpos;
  assign req.speed  = latest_speed;

  mcpid_core #(
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .start (item_accept && item.cmd == CMD_CONTROL),
    .req   (req),
    .idle  (core_idle),
    .done  (core_done),
    .take  (core_take),
    .res   (res)
  );

  // output register
  assign core_take = core_done && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (core_take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_take) begin
      result.drive_current  <= res.drive;
      result.total_position <= tpos;
      result.output_clamped <= res.clamped;
    end
  end

  // a feedback frame never yields a beat
  a_feedback_silent: assert property (@(posedge clk) disable iff (rst)
    (item_accept && item.cmd == CMD_FEEDBACK && !result.valid) |=> !result.valid)
    else $error("result beat after feedback frame");

  // a clamped beat sits exactly on the limit
  a_clamp_on_limit: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.output_clamped) |->
      (result.drive_current == $signed({1'b0, cfg.max_output}) ||
       result.drive_current == -$signed({1'b0, cfg.max_output})))
    else $error("clamped output off the limit");

  // a control tick occupies the engine on the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (item_accept && item.cmd == CMD_CONTROL) |=> !item.ready)
    else $error("item taken while engine busy");

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the cascaded position/velocity PID controller
// A directed table checks pass-through, stop, round-counter wrapping and the
// integrator and clamp corners. Random phases then send mixed feedback frames
// and control ticks under changing gains. Result beats are compared with
// typed-in values or with a cycle-free predictor of the block's fixed-point loops.
// ----------------------------------------------------------------------------
module tb_top;
  import mcpid_pkg::*;

  localparam int COUNTS_PER_TURN    = 8192;
  localparam int GAIN_FRACTION_BITS = 16;
  localparam int IDLE_PCT           = 29;
  localparam int DRAIN_CYCLES       = 40;   // longest tick latency plus margin
  localparam int RAND_PHASES        = 6;
  localparam int PHASE_ITEMS        = 150;
  localparam int STEADY_PHASE       = 3;    // no idling on either side here
  localparam int MAX_MSGS           = 40;
  localparam int VEL_LOOP           = 0;
  localparam int POS_LOOP           = 1;
  localparam longint INTEG_HI       = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INTEG_LO       = -INTEG_HI - 1;

  typedef struct packed {
    logic                       cmd;
    logic [ANGLE_W-1:0]         angle;
    logic signed [SPEED_W-1:0]  speed;
    logic [MODE_W-1:0]          mode;
    logic signed [TARGET_W-1:0] target;
    logic                       clr;
  } ctl_item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic signed [TPOS_W-1:0]  tpos;
    logic                      clamped;
  } drive_res_t;

  typedef struct packed {
    logic [1:0] cfg_sel;
    ctl_item_t  stim;
    logic       chk;     // compare against the typed-in beat
    drive_res_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [IDX_W-1:0] wr_index;
  logic [CFG_W-1:0] wr_data;
  logic steady = 1'b0;

  mcpid_item_if   item_bus();
  mcpid_result_if result_bus();

  motor_cascade_pid_controller #(
    .COUNTS_PER_TURN(COUNTS_PER_TURN),
    .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .item(item_bus),
    .result(result_bus),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register settings used by the directed table
  cfg_t reg_sets [0:3] = '{
    '{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, MAXOUT_RESET, 13'd0},
    '{24'h018000, 24'h000800, 24'h004000, 24'h002000, 24'h000100, 24'h001000,
      15'd20000, 13'd1234},
    '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
      15'h7FFF, 13'h1FFF},
    '{24'h010000, 24'h000400, 24'h002000, 24'h008000, 24'h000200, 24'h000800,
      15'd0, 13'd0}
  };

  dir_row_t directed_rows [0:24] = '{
    // reset settings: pass-through, stop, zero gains, half-turn rule
    '{0, '{CMD_CONTROL,  0,    0,      MODE_CURRENT,  0,             0}, 1, '{0, 0, 0}},
    '{0, '{CMD_CONTROL,  0,    0,      MODE_CURRENT,  32'h7FFF_FFFF, 0}, 1, '{32767, 0, 0}},
    '{0, '{CMD_CONTROL,  0,    0,      MODE_CURRENT,  32'h8000_0000, 0}, 1, '{-32768, 0, 0}},
    '{0, '{CMD_CONTROL,  0,    0,      MODE_STOP,     12345,         1}, 1, '{0, 0, 0}},
    '{0, '{CMD_CONTROL,  0,    0,      MODE_VELOCITY, 1000,          0}, 1, '{0, 0, 0}},
    '{0, '{CMD_FEEDBACK, 8191, 32767,  MODE_CURRENT,  0,             0}, 0, '{0, 0, 0}},
    '{0, '{CMD_CONTROL,  0,    0,      MODE_STOP,     0,             0}, 1, '{0, -1, 0}},
    '{0, '{CMD_FEEDBACK, 0,    -32768, MODE_CURRENT,  0,             0}, 0, '{0, 0, 0}},
    '{0, '{CMD_CONTROL,  0,    0,      MODE_CURRENT,  32768,         0}, 1, '{32767, 0, 0}},
    '{0, '{CMD_FEEDBACK, 4097, 0,      MODE_CURRENT,  0,             0}, 0, '{0, 0, 0}},
    '{0, '{CMD_CONTROL,  0,    0,      MODE_CURRENT,  -32769,        0}, 1, '{-32768, -4095, 0}},
    '{0, '{CMD_FEEDBACK, 0,    0,      MODE_CURRENT,  0,             0}, 0, '{0, 0, 0}},
    '{0, '{CMD_FEEDBACK, 4096, 0,      MODE_CURRENT,  0,             0}, 0, '{0, 0, 0}},
    '{0, '{CMD_FEEDBACK, 0,    0,      MODE_CURRENT,  0,             0}, 0, '{0, 0, 0}},
    '{0, '{CMD_CONTROL,  0,    0,      MODE_STOP,     32'h7FFF_FFFF, 0}, 1, '{0, 0, 0}},
    // moderate gains with an angle offset
    '{1, '{CMD_FEEDBACK, 100,  1500,   MODE_CURRENT,  0,             0}, 0, '{0, 0, 0}},
    '{1, '{CMD_CONTROL,  0,    0,      MODE_VELOCITY, 3000,          0}, 0, '{0, 0, 0}},
    '{1, '{CMD_CONTROL,  0,    0,      MODE_VELOCITY, -3000,         1}, 0, '{0, 0, 0}},
    '{1, '{CMD_CONTROL,  0,    0,      MODE_POSITION, 50000,         0}, 0, '{0, 0, 0}},
    '{1, '{CMD_CONTROL,  0,    0,      MODE_POSITION, 32'h8000_0000, 0}, 0, '{0, 0, 0}},
    // all gains maxed: integrators saturate, both loops clamp
    '{2, '{CMD_CONTROL,  0,    0,      MODE_VELOCITY, 32'h7FFF_FFFF, 0}, 0, '{0, 0, 0}},
    '{2, '{CMD_CONTROL,  0,    0,      MODE_POSITION, 32'h8000_0000, 0}, 0, '{0, 0, 0}},
    '{2, '{CMD_CONTROL,  0,    0,      MODE_POSITION, 32'h7FFF_FFFF, 1}, 0, '{0, 0, 0}},
    // zero output limit
    '{3, '{CMD_CONTROL,  0,    0,      MODE_VELOCITY, 777,           0}, 0, '{0, 0, 0}},
    '{3, '{CMD_CONTROL,  0,    0,      MODE_POSITION, -777,          0}, 0, '{0, 0, 0}}
  };

  // predictor state
  cfg_t                      regs;
  logic [ANGLE_W-1:0]        angle_prev, angle_now;
  logic signed [ROUND_W-1:0] rounds;
  logic signed [SPEED_W-1:0] speed_now;
  longint                    loop_integ [2];
  longint                    loop_last_err [2];

  drive_res_t pending_results [$];
  int         mismatch_cnt = 0;

  task automatic note_mismatch(input string msg);
    if (mismatch_cnt < MAX_MSGS) $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  function automatic logic signed [TPOS_W-1:0] current_tpos();
    longint full;
    full = longint'(rounds) * COUNTS_PER_TURN + longint'(angle_now)
         - longint'(regs.offset_angle);
    return full[TPOS_W-1:0];
  endfunction

  // one PID pass; integrator saturates at 48 bits, output floors then clamps
  function automatic longint step_loop(input int idx, input longint goal,
                                       input longint meas, output logic hit);
    longint kp, ki, kd, err, inc, total, outv, lim;
    if (idx == VEL_LOOP) begin
      kp = longint'(regs.kp_vel);
      ki = longint'(regs.ki_vel);
      kd = longint'(regs.kd_vel);
    end else begin
      kp = longint'(regs.kp_pos);
      ki = longint'(regs.ki_pos);
      kd = longint'(regs.kd_pos);
    end
    err = goal - meas;
    inc = ki * err;
    if (inc > 0 && loop_integ[idx] > INTEG_HI - inc) loop_integ[idx] = INTEG_HI;
    else if (inc < 0 && loop_integ[idx] < INTEG_LO - inc) loop_integ[idx] = INTEG_LO;
    else loop_integ[idx] = loop_integ[idx] + inc;
    total = kp * err + loop_integ[idx] + kd * (err - loop_last_err[idx]);
    loop_last_err[idx] = err;
    outv = total >>> GAIN_FRACTION_BITS;
    lim = longint'(regs.max_output);
    hit = 1'b0;
    if (outv > lim) begin
      outv = lim;
      hit = 1'b1;
    end else if (outv < -lim) begin
      outv = -lim;
      hit = 1'b1;
    end
    return outv;
  endfunction

  // returns 1 when the item yields a result beat
  function automatic logic predict_drive(input ctl_item_t it, output drive_res_t res);
    int                         diff;
    longint                     drive, vel_goal, tgt;
    logic                       hit, pos_hit;
    logic signed [TPOS_W-1:0]   tpos;
    logic signed [TARGET_W-1:0] target;
    res = '0;
    if (it.cmd == CMD_FEEDBACK) begin
      angle_prev = angle_now;
      angle_now = it.angle;
      speed_now = it.speed;
      diff = int'(angle_now) - int'(angle_prev);
      if (diff > COUNTS_PER_TURN / 2) rounds = rounds - ROUND_W'(1);
      else if (diff < -(COUNTS_PER_TURN / 2)) rounds = rounds + ROUND_W'(1);
      return 1'b0;
    end
    if (it.clr) begin
      loop_integ[VEL_LOOP] = 0;
      loop_integ[POS_LOOP] = 0;
    end
    tpos = current_tpos();
    target = it.target;
    tgt = longint'(target);
    hit = 1'b0;
    case (it.mode)
      MODE_CURRENT: begin
        drive = tgt > 32767 ? 32767 : (tgt < -32768 ? -32768 : tgt);
      end
      MODE_VELOCITY: begin
        drive = step_loop(VEL_LOOP, tgt, longint'(speed_now), hit);
      end
      MODE_POSITION: begin
        vel_goal = step_loop(POS_LOOP, tgt, longint'(tpos), pos_hit);
        drive = step_loop(VEL_LOOP, vel_goal, longint'(speed_now), hit);
      end
      default: drive = 0;
    endcase
    res.drive = drive[DRIVE_W-1:0];
    res.tpos = tpos;
    res.clamped = hit;
    return 1'b1;
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(input ctl_item_t it, input logic use_typed,
                           input drive_res_t typed);
    drive_res_t res;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      item_bus.valid <= 1'b0;
      @(negedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.cmd <= it.cmd;
    item_bus.rotor_angle <= it.angle;
    item_bus.rotor_speed <= it.speed;
    item_bus.mode <= it.mode;
    item_bus.target <= it.target;
    item_bus.clear_integrals <= it.clr;
    do @(posedge clk); while (!item_bus.ready);
    if (predict_drive(it, res)) pending_results.push_back(use_typed ? typed : res);
    @(negedge clk);
  endtask

  task automatic settle();
    item_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // feedback frames leave nothing pending, so give the engine time to go idle
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
  endtask

  task automatic load_regs(input cfg_t c);
    write_reg(REG_KP_VEL, c.kp_vel);
    write_reg(REG_KI_VEL, c.ki_vel);
    write_reg(REG_KD_VEL, c.kd_vel);
    write_reg(REG_KP_POS, c.kp_pos);
    write_reg(REG_KI_POS, c.ki_pos);
    write_reg(REG_KD_POS, c.kd_pos);
    write_reg(REG_MAXOUT, CFG_W'(c.max_output));
    write_reg(REG_OFFSET, CFG_W'(c.offset_angle));
    wr_en <= 1'b0;
    regs = c;
  endtask

  function automatic logic [GAIN_W-1:0] rand_gain(input int unsigned top);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return GAIN_W'($urandom_range(top));
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.kp_vel = rand_gain(24'h040000);
    c.ki_vel = rand_gain(24'h004000);
    c.kd_vel = rand_gain(24'h020000);
    c.kp_pos = rand_gain(24'h010000);
    c.ki_pos = rand_gain(24'h001000);
    c.kd_pos = rand_gain(24'h008000);
    case ($urandom_range(9))
      0: c.max_output = '0;
      1: c.max_output = '1;
      default: c.max_output = MAXO_W'($urandom_range(30000, 1));
    endcase
    c.offset_angle = ANGLE_W'($urandom_range(COUNTS_PER_TURN - 1));
    return c;
  endfunction

  // mostly smooth rotor motion and plausible targets, with wild values mixed in
  function automatic ctl_item_t make_random_item();
    ctl_item_t it;
    int        delta, pos;
    logic [31:0] raw;
    raw = $urandom;
    it.mode = MODE_W'($urandom_range(3));
    it.clr = ($urandom_range(19) == 0);
    it.target = $urandom;
    it.speed = raw[SPEED_W-1:0];
    it.angle = ANGLE_W'($urandom_range(COUNTS_PER_TURN - 1));
    if ($urandom_range(99) < 45) begin
      it.cmd = CMD_FEEDBACK;
      case ($urandom_range(9))
        0: delta = -1;   // keep the jump-anywhere angle
        1: begin
          delta = $urandom_range(1) ? COUNTS_PER_TURN / 2 : COUNTS_PER_TURN / 2 + 1;
          if ($urandom_range(1)) delta = -delta;
        end
        default: delta = int'($urandom_range(600)) - 300;
      endcase
      if (delta != -1) begin
        pos = int'(angle_now) + delta;
        it.angle = pos[ANGLE_W-1:0];
      end
      case ($urandom_range(9))
        0: it.speed = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        1: ;
        default: it.speed = SPEED_W'(int'($urandom_range(6000)) - 3000);
      endcase
    end else begin
      it.cmd = CMD_CONTROL;
      case ($urandom_range(9))
        0: ;
        1: it.target = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: begin
          case (it.mode)
            MODE_CURRENT:  it.target = int'($urandom_range(80000)) - 40000;
            MODE_VELOCITY: it.target = int'($urandom_range(12000)) - 6000;
            MODE_POSITION: it.target = current_tpos() + int'($urandom_range(40000)) - 20000;
            default: ;
          endcase
        end
      endcase
    end
    return it;
  endfunction

  always @(negedge clk) result_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin
    drive_res_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (result_bus.drive_current !== want.drive)
          note_mismatch($sformatf("drive_current %0d, want %0d",
                                  result_bus.drive_current, want.drive));
        if (result_bus.total_position !== want.tpos)
          note_mismatch($sformatf("total_position %0d, want %0d",
                                  result_bus.total_position, want.tpos));
        if (result_bus.output_clamped !== want.clamped)
          note_mismatch($sformatf("output_clamped %0b, want %0b",
                                  result_bus.output_clamped, want.clamped));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    dir_row_t row;
    int       cur_set;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = REG_KP_VEL;
    wr_data = '0;
    item_bus.valid = 1'b0;
    item_bus.cmd = CMD_FEEDBACK;
    item_bus.rotor_angle = '0;
    item_bus.rotor_speed = '0;
    item_bus.mode = MODE_CURRENT;
    item_bus.target = '0;
    item_bus.clear_integrals = 1'b0;
    result_bus.ready = 1'b0;
    regs = reg_sets[0];
    angle_prev = '0;
    angle_now = '0;
    rounds = '0;
    speed_now = '0;
    loop_integ[VEL_LOOP] = 0;
    loop_integ[POS_LOOP] = 0;
    loop_last_err[VEL_LOOP] = 0;
    loop_last_err[POS_LOOP] = 0;
    cur_set = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (int'(row.cfg_sel) != cur_set) begin
        settle();
        load_regs(reg_sets[row.cfg_sel]);
        cur_set = int'(row.cfg_sel);
      end
      send_item(row.stim, row.chk, row.want);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      load_regs(rand_cfg());
      steady = (p == STEADY_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(make_random_item(), 1'b0, '0);
    end
    settle();

    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
